@@ rtl/slr_pkg.sv @@
// shared constants, types and helpers for the subtractive lagged random core
package slr_pkg;

  parameter int FRACTION_BITS_DEF = 24;
  parameter int MIX_ROUNDS_DEF    = 4;

  localparam int VAL_W  = 30;
  localparam int SEED_W = 28;
  localparam int SLOT_W = 6;
  localparam int REM_W  = 32;

  localparam logic [VAL_W-1:0]  MODULUS     = 30'd1000000000;
  localparam logic [SEED_W-1:0] SEED_BASE   = 28'd161803398;
  localparam logic [SLOT_W-1:0] TABLE_LEN   = 6'd55;
  localparam logic [SLOT_W-1:0] SEED_STRIDE = 6'd21;
  localparam logic [SLOT_W-1:0] MIX_OFFSET  = 6'd30;
  localparam logic [SLOT_W-1:0] TRAIL_START = 6'd31;

  typedef struct packed {
    logic s1;
    logic s2;
  } frac_ld_t;

  // difference modulo one billion
  function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] t;
    if (a >= b) begin
      t = {1'b0, a} - {1'b0, b};
    end else begin
      t = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
    end
    return t[VAL_W-1:0];
  endfunction

  // pointer step over positions 1..55
  function automatic logic [SLOT_W-1:0] step_pos(input logic [SLOT_W-1:0] p);
    if (p >= TABLE_LEN) begin
      return 6'd1;
    end else begin
      return p + 6'd1;
    end
  endfunction

endpackage

@@ rtl/slr_ifs.sv @@
// command and result channel interfaces
interface slr_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [slr_pkg::SEED_W-1:0] seed;

  modport source (output valid, output action, output seed, input ready);
  modport sink (input valid, input action, input seed, output ready);
endinterface

interface slr_rnd_if #(
  parameter int FRACTION_BITS = slr_pkg::FRACTION_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [slr_pkg::VAL_W-1:0] raw_value;
  logic [FRACTION_BITS-1:0]  unit_fraction;

  modport source (output valid, output raw_value, output unit_fraction, input ready);
  modport sink (input valid, input raw_value, input unit_fraction, output ready);
endinterface

@@ rtl/slr_table_mem.sv @@
// lag table: one write port, two registered read ports
module slr_table_mem (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [slr_pkg::SLOT_W-1:0] rd_addr_a,
  input  logic [slr_pkg::SLOT_W-1:0] rd_addr_b,
  output logic [slr_pkg::VAL_W-1:0]  rd_data_a,
  output logic [slr_pkg::VAL_W-1:0]  rd_data_b,
  input  logic                       wr_en,
  input  logic [slr_pkg::SLOT_W-1:0] wr_addr,
  input  logic [slr_pkg::VAL_W-1:0]  wr_data
);
  import slr_pkg::*;

  logic [VAL_W-1:0] mem [0:TABLE_LEN-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ rtl/slr_frac.sv @@
// fraction scaling: reciprocal multiply, back multiply, one-step correction
module slr_frac #(
  parameter int FRACTION_BITS = slr_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  slr_pkg::frac_ld_t         ld,
  input  logic [slr_pkg::VAL_W-1:0] value,
  output logic [slr_pkg::VAL_W-1:0] raw_value,
  output logic [FRACTION_BITS-1:0]  unit_fraction
);
  import slr_pkg::*;

  localparam int PROD_W = VAL_W + FRACTION_BITS + 1;
  localparam int QM_W   = VAL_W + FRACTION_BITS;
  localparam logic [63:0] RECIP_FULL =
    (64'd1 << (FRACTION_BITS + VAL_W)) / 64'd1000000000;
  localparam logic [FRACTION_BITS:0] RECIP = RECIP_FULL[FRACTION_BITS:0];

  logic [VAL_W-1:0]         v1;
  logic [FRACTION_BITS-1:0] q1;
  logic [VAL_W-1:0]         v2;
  logic [FRACTION_BITS-1:0] q2;
  logic [REM_W-1:0]         qm2;

  logic [PROD_W-1:0]              prod;
  logic [QM_W-1:0]                qmul;
  logic [VAL_W+FRACTION_BITS-1:0] vsh;
  logic [REM_W-1:0]               rem;
  logic                           fix;

  // estimate is the true quotient or one below it
  assign prod = PROD_W'(value) * PROD_W'(RECIP);
  assign qmul = QM_W'(q1) * QM_W'(MODULUS);

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      v1 <= value;
      q1 <= prod[VAL_W+FRACTION_BITS-1:VAL_W];
    end
    if (ld.s2) begin
      v2  <= v1;
      q2  <= q1;
      qm2 <= qmul[REM_W-1:0];
    end
  end

  assign vsh = {v2, {FRACTION_BITS{1'b0}}};
  assign rem = vsh[REM_W-1:0] - qm2;
  assign fix = (rem >= REM_W'(MODULUS));

  assign raw_value     = v2;
  assign unit_fraction = q2 + FRACTION_BITS'(fix);

endmodule

@@ rtl/subtractive_lagged_random_core.sv @@
// subtractive lagged random generator top level
//
//  channel | dir | payload                       | beat when
//  cmd     | in  | action, seed                  | cmd.valid && cmd.ready
//  rnd     | out | raw_value, unit_fraction      | rnd.valid && rnd.ready
//
// a draw runs from beat to beat through table read, write back with first multiply,
// second multiply, output register
// seeding (reseed or first draw) adds a table fill and the mixing rounds, one table write
// or one read-modify-write on the two-read-port table per cycle
// rst clears control state only; the table holds nothing valid until the first seeding
// a waiting result does not block the next command beat; the next result then
// holds in the fraction unit until rnd is free
module subtractive_lagged_random_core #(
  parameter int FRACTION_BITS = slr_pkg::FRACTION_BITS_DEF,
  parameter int MIX_ROUNDS    = slr_pkg::MIX_ROUNDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  slr_cmd_if.sink   cmd,
  slr_rnd_if.source rnd
);
  import slr_pkg::*;

  localparam int RND_W = (MIX_ROUNDS > 1) ? $clog2(MIX_ROUNDS) : 1;
  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(MIX_ROUNDS - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SEED = 7'b0000010,
    ST_MIX  = 7'b0000100,
    ST_DRAW = 7'b0001000,
    ST_WB   = 7'b0010000,
    ST_MUL  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic              seeded;
  logic [SLOT_W-1:0] lead;
  logic [SLOT_W-1:0] trail;
  logic [SLOT_W-1:0] seed_cnt;
  logic [SLOT_W-1:0] seed_pos;
  logic [VAL_W-1:0]  prev;
  logic [VAL_W-1:0]  cur;
  logic [SLOT_W-1:0] mix_a;
  logic [SLOT_W-1:0] mix_b;
  logic [RND_W-1:0]  mix_round;
  logic              wb_valid;
  logic [SLOT_W-1:0] wb_slot;
  logic              out_valid;
  logic [VAL_W-1:0]  out_raw;
  logic [FRACTION_BITS-1:0] out_frac;

  logic              accept;
  logic              need_seed;
  logic              issue_draw;
  logic              issue_mix;
  logic              out_free;
  logic [SEED_W-1:0] seed_sat;
  logic [SLOT_W-1:0] lead_step;
  logic [SLOT_W-1:0] trail_step;
  logic [SLOT_W:0]   pos_sum;
  logic [SLOT_W-1:0] pos_next;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr_a;
  logic [SLOT_W-1:0] rd_addr_b;
  logic [VAL_W-1:0]  rd_data_a;
  logic [VAL_W-1:0]  rd_data_b;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [VAL_W-1:0]  diff;

  frac_ld_t                 frac_ld;
  logic [VAL_W-1:0]         frac_raw;
  logic [FRACTION_BITS-1:0] frac_val;

  assign cmd.ready  = (state == ST_IDLE);
  assign accept     = cmd.valid && cmd.ready;
  assign need_seed  = cmd.action || !seeded;
  assign issue_draw = (accept && !need_seed) || (state == ST_DRAW);
  assign issue_mix  = (state == ST_MIX);
  assign out_free   = !out_valid || rnd.ready;
  assign seed_sat   = (cmd.seed > SEED_BASE) ? SEED_BASE : cmd.seed;

  assign lead_step  = step_pos(lead);
  assign trail_step = step_pos(trail);
  assign pos_sum    = {1'b0, seed_pos} + {1'b0, SEED_STRIDE};
  assign pos_next   = (pos_sum >= {1'b0, TABLE_LEN}) ?
                      SLOT_W'(pos_sum - {1'b0, TABLE_LEN}) : SLOT_W'(pos_sum);

  // table ports
  assign rd_en     = issue_draw || issue_mix;
  assign rd_addr_a = issue_mix ? mix_a : lead_step - 6'd1;
  assign rd_addr_b = issue_mix ? mix_b : trail_step - 6'd1;
  assign diff      = sub_mod(rd_data_a, rd_data_b);

  always_comb begin
    wr_en   = wb_valid;
    wr_addr = wb_slot;
    wr_data = diff;
    if (state == ST_SEED) begin
      wr_en = 1'b1;
      if (seed_cnt == '0) begin
        wr_addr = TABLE_LEN - 6'd1;
        wr_data = prev;
      end else begin
        wr_addr = seed_pos - 6'd1;
        wr_data = cur;
      end
    end
  end

  slr_table_mem u_table (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  assign frac_ld.s1 = (state == ST_WB);
  assign frac_ld.s2 = (state == ST_MUL);

  slr_frac #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_frac (
    .clk           (clk),
    .ld            (frac_ld),
    .value         (diff),
    .raw_value     (frac_raw),
    .unit_fraction (frac_val)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = need_seed ? ST_SEED : ST_WB;
        end
      end
      ST_SEED: begin
        if (seed_cnt == TABLE_LEN - 6'd1) begin
          state_next = ST_MIX;
        end
      end
      ST_MIX: begin
        if (mix_a == TABLE_LEN - 6'd1 && mix_round == LAST_ROUND) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: state_next = ST_WB;
      ST_WB:   state_next = ST_MUL;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seeded    <= 1'b0;
      lead      <= '0;
      trail     <= TRAIL_START;
      wb_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wb_valid <= issue_draw || issue_mix;
      if (issue_draw) begin
        lead  <= lead_step;
        trail <= trail_step;
      end
      if (state == ST_MIX && state_next == ST_DRAW) begin
        lead   <= '0;
        trail  <= TRAIL_START;
        seeded <= 1'b1;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (rnd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // seeding, mixing, write-back slot and output register datapath
  always_ff @(posedge clk) begin
    if (issue_draw) begin
      wb_slot <= lead_step - 6'd1;
    end else if (issue_mix) begin
      wb_slot <= mix_a;
    end
    if (accept && need_seed) begin
      prev     <= VAL_W'(SEED_BASE - seed_sat);
      cur      <= VAL_W'(1);
      seed_cnt <= '0;
      seed_pos <= SEED_STRIDE;
    end else if (state == ST_SEED) begin
      seed_cnt <= seed_cnt + 6'd1;
      if (seed_cnt != '0) begin
        cur      <= sub_mod(prev, cur);
        prev     <= cur;
        seed_pos <= pos_next;
      end
    end
    if (state == ST_SEED) begin
      mix_a     <= '0;
      mix_b     <= MIX_OFFSET + 6'd1;
      mix_round <= '0;
    end else if (issue_mix) begin
      mix_a <= (mix_a == TABLE_LEN - 6'd1) ? '0 : mix_a + 6'd1;
      mix_b <= (mix_b == TABLE_LEN - 6'd1) ? '0 : mix_b + 6'd1;
      if (mix_a == TABLE_LEN - 6'd1) begin
        mix_round <= mix_round + RND_W'(1);
      end
    end
    if (state == ST_OUT && out_free) begin
      out_raw  <= frac_raw;
      out_frac <= frac_val;
    end
  end

  assign rnd.valid         = out_valid;
  assign rnd.raw_value     = out_raw;
  assign rnd.unit_fraction = out_frac;

endmodule

@@ rtl/slr_checker.sv @@
// port-level checks for the subtractive lagged random core, bound to the top level
module slr_checker #(
  parameter int FRACTION_BITS = slr_pkg::FRACTION_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic                      rnd_valid,
  input logic                      rnd_ready,
  input logic [slr_pkg::VAL_W-1:0] raw_value,
  input logic [FRACTION_BITS-1:0]  unit_fraction
);
  import slr_pkg::*;

  logic       cmd_beat;
  logic       rnd_beat;
  logic [1:0] pending;

  assign cmd_beat = cmd_valid && cmd_ready;
  assign rnd_beat = rnd_valid && rnd_ready;

  // commands taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(cmd_beat) - 2'(rnd_beat);
    end
  end

  a_rnd_hold: assert property (@(posedge clk) disable iff (rst)
    rnd_valid && !rnd_ready |=> rnd_valid && $stable(raw_value) && $stable(unit_fraction))
    else $error("result beat dropped or changed while stalled");

  a_raw_range: assert property (@(posedge clk) disable iff (rst)
    rnd_valid |-> raw_value < MODULUS)
    else $error("raw value not below one billion");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_beat |=> !cmd_ready)
    else $error("command taken while previous one still in work");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rnd_valid |-> pending != 2'd0)
    else $error("result without a command");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two commands outstanding");

endmodule

bind subtractive_lagged_random_core slr_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_slr_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rnd_valid     (rnd.valid),
  .rnd_ready     (rnd.ready),
  .raw_value     (rnd.raw_value),
  .unit_fraction (rnd.unit_fraction)
);
